// ===== rtl/imucal_pkg.sv =====
`default_nettype none

package imucal_pkg;

  localparam int DATA_W = 16;
  localparam int SUM_W  = 24;
  localparam int CNT_W  = 8;
  localparam int CMD_W  = 2;
  localparam int GYRO_AXES  = 3;
  localparam int ACCEL_AXES = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE        = 2'd0,
    CMD_GYRO_RESTART  = 2'd1,
    CMD_ACCEL_RESTART = 2'd2,
    CMD_NONE          = 2'd3
  } cmd_t;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic start;
    logic is_accel;
  } div_req_t;

  typedef struct packed {
    logic valid;
    logic is_accel;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/imucal_div.sv =====
`default_nettype none

module imucal_div #(
  parameter int CAL_SAMPLES = 200
) (
  input  logic                clk,
  input  logic                rst,
  input  imucal_pkg::div_req_t req,
  input  imucal_pkg::sum_t    sum  [imucal_pkg::GYRO_AXES],
  output imucal_pkg::div_rsp_t rsp,
  output imucal_pkg::data_t   quot [imucal_pkg::GYRO_AXES]
);
  import imucal_pkg::*;

  localparam int SHIFT = SUM_W + $clog2(CAL_SAMPLES);
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam int RW = $clog2(RECIP + 64'd1);
  localparam int PW = SUM_W + RW;
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

  logic [SUM_W-1:0]  mag  [GYRO_AXES];
  logic [PW-1:0]     prod [GYRO_AXES];
  logic              neg  [GYRO_AXES];
  logic [DATA_W-1:0] qmag [GYRO_AXES];

  always_comb begin
    for (int i = 0; i < GYRO_AXES; i++) begin
      mag[i] = sum[i][SUM_W-1] ? SUM_W'(-sum[i]) : SUM_W'(sum[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= req.start;
    end
    rsp.is_accel <= req.is_accel;
    for (int i = 0; i < GYRO_AXES; i++) begin
      neg[i]  <= sum[i][SUM_W-1];
      prod[i] <= PW'(mag[i]) * PW'(RECIP_V);
    end
  end

  always_comb begin
    for (int i = 0; i < GYRO_AXES; i++) begin
      qmag[i] = DATA_W'(prod[i] >> SHIFT);
      quot[i] = neg[i] ? data_t'(-qmag[i]) : data_t'(qmag[i]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imu_offset_calibration_unit.sv =====
// Channel  | Handshake                        | Payload
// ---------+----------------------------------+----------------------------------------------
// sample   | sample_valid / sample_stall      | command, accel_*_raw, gyro_*_raw
// result   | result_valid / result_stall      | accel_*, gyro_*, *_offset_saved, *_calibrated
//
// One transaction per cycle unless stalled; a sample's result comes in the next cycle.
// A sample that ends a calibration stalls the sample side while the offset divider
// (reciprocal multiply, then shift) registers the product and writes the new offsets.
// Restart commands and unused command codes give no result.
// sample_stall also follows a stalled, full result register.
// rst is synchronous: offsets, sums and counters clear, both calibrations pending.
`default_nettype none

module imu_offset_calibration_unit #(
  parameter int CAL_SAMPLES = 200
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  imucal_pkg::cmd_t  command,
  input  imucal_pkg::data_t accel_x_raw,
  input  imucal_pkg::data_t accel_y_raw,
  input  imucal_pkg::data_t accel_z_raw,
  input  imucal_pkg::data_t gyro_x_raw,
  input  imucal_pkg::data_t gyro_y_raw,
  input  imucal_pkg::data_t gyro_z_raw,
  output logic              result_valid,
  input  logic              result_stall,
  output imucal_pkg::data_t accel_x,
  output imucal_pkg::data_t accel_y,
  output imucal_pkg::data_t accel_z,
  output imucal_pkg::data_t gyro_x,
  output imucal_pkg::data_t gyro_y,
  output imucal_pkg::data_t gyro_z,
  output logic              gyro_offset_saved,
  output logic              accel_offset_saved,
  output logic              gyro_calibrated,
  output logic              accel_calibrated
);
  import imucal_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(CAL_SAMPLES);

  data_t            gyro_bias    [GYRO_AXES];
  data_t            accel_bias   [ACCEL_AXES];
  sum_t             gyro_sum     [GYRO_AXES];
  sum_t             accel_sum    [ACCEL_AXES];
  logic [CNT_W-1:0] gyro_count, accel_count;
  logic             gyro_done, accel_done;
  div_req_t         div_req;

  sum_t             gyro_sum_next  [GYRO_AXES];
  sum_t             accel_sum_next [ACCEL_AXES];
  logic [CNT_W-1:0] gyro_count_next, accel_count_next;
  logic             gyro_done_next, accel_done_next;
  div_req_t         div_req_next;
  logic             gyro_clear, accel_clear, gsaved, asaved, skip;

  data_t            gyr_c [GYRO_AXES];
  data_t            acc_c [ACCEL_AXES];
  data_t            gyr_raw [GYRO_AXES];
  data_t            acc_raw [ACCEL_AXES];
  logic             accept, take_sample;

  sum_t             div_sum  [GYRO_AXES];
  div_rsp_t         div_rsp;
  data_t            div_quot [GYRO_AXES];

  assign accept       = sample_valid && !sample_stall;
  assign take_sample  = accept && (command == CMD_SAMPLE);
  assign sample_stall = div_req.start || div_rsp.valid || (result_valid && result_stall);

  assign gyr_raw[0] = gyro_x_raw;
  assign gyr_raw[1] = gyro_y_raw;
  assign gyr_raw[2] = gyro_z_raw;
  assign acc_raw[0] = accel_x_raw;
  assign acc_raw[1] = accel_y_raw;

  always_comb begin
    for (int i = 0; i < GYRO_AXES; i++) begin
      gyr_c[i] = gyr_raw[i] - gyro_bias[i];
    end
    for (int i = 0; i < ACCEL_AXES; i++) begin
      acc_c[i] = acc_raw[i] - accel_bias[i];
    end
  end

  always_comb begin
    gyro_sum_next    = gyro_sum;
    accel_sum_next   = accel_sum;
    gyro_count_next  = gyro_count;
    accel_count_next = accel_count;
    gyro_done_next   = gyro_done;
    accel_done_next  = accel_done;
    div_req_next     = '{start: 1'b0, is_accel: div_req.is_accel};
    gyro_clear       = 1'b0;
    accel_clear      = 1'b0;
    gsaved           = 1'b0;
    asaved           = 1'b0;
    skip             = 1'b0;
    if (take_sample) begin
      if (!gyro_done) begin
        if (gyro_count == '0) begin
          gyro_clear = 1'b1;
          for (int i = 0; i < GYRO_AXES; i++) begin
            gyro_sum_next[i] = '0;
          end
          gyro_count_next = CNT_W'(1);
          skip = 1'b1;
        end else begin
          for (int i = 0; i < GYRO_AXES; i++) begin
            gyro_sum_next[i] = gyro_sum[i]
              + {{(SUM_W-DATA_W){gyr_c[i][DATA_W-1]}}, gyr_c[i]};
          end
          if (gyro_count >= LAST) begin
            gyro_count_next = '0;
            gyro_done_next  = 1'b1;
            gsaved          = 1'b1;
            skip            = 1'b1;
            div_req_next    = '{start: 1'b1, is_accel: 1'b0};
          end else begin
            gyro_count_next = gyro_count + CNT_W'(1);
          end
        end
      end
      if (!skip && !accel_done) begin
        if (accel_count == '0) begin
          accel_clear = 1'b1;
          for (int i = 0; i < ACCEL_AXES; i++) begin
            accel_sum_next[i] = '0;
          end
          accel_count_next = CNT_W'(1);
        end else begin
          for (int i = 0; i < ACCEL_AXES; i++) begin
            accel_sum_next[i] = accel_sum[i]
              + {{(SUM_W-DATA_W){acc_c[i][DATA_W-1]}}, acc_c[i]};
          end
          if (accel_count >= LAST) begin
            accel_count_next = '0;
            accel_done_next  = 1'b1;
            asaved           = 1'b1;
            div_req_next     = '{start: 1'b1, is_accel: 1'b1};
          end else begin
            accel_count_next = accel_count + CNT_W'(1);
          end
        end
      end
    end else if (accept && command == CMD_GYRO_RESTART) begin
      gyro_done_next  = 1'b0;
      gyro_count_next = '0;
    end else if (accept && command == CMD_ACCEL_RESTART) begin
      accel_done_next  = 1'b0;
      accel_count_next = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < GYRO_AXES; i++) begin
      div_sum[i] = gyro_sum[i];
    end
    if (div_req.is_accel) begin
      div_sum[0] = accel_sum[0];
      div_sum[1] = accel_sum[1];
      div_sum[2] = '0;
    end
  end

  imucal_div #(
    .CAL_SAMPLES(CAL_SAMPLES)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .sum  (div_sum),
    .rsp  (div_rsp),
    .quot (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GYRO_AXES; i++) begin
        gyro_bias[i] <= '0;
        gyro_sum[i]  <= '0;
      end
      for (int i = 0; i < ACCEL_AXES; i++) begin
        accel_bias[i] <= '0;
        accel_sum[i]  <= '0;
      end
      gyro_count   <= '0;
      accel_count  <= '0;
      gyro_done    <= 1'b0;
      accel_done   <= 1'b0;
      div_req      <= '0;
      result_valid <= 1'b0;
    end else begin
      gyro_sum    <= gyro_sum_next;
      accel_sum   <= accel_sum_next;
      gyro_count  <= gyro_count_next;
      accel_count <= accel_count_next;
      gyro_done   <= gyro_done_next;
      accel_done  <= accel_done_next;
      div_req     <= div_req_next;
      for (int i = 0; i < GYRO_AXES; i++) begin
        if (gyro_clear) begin
          gyro_bias[i] <= '0;
        end else if (div_rsp.valid && !div_rsp.is_accel) begin
          gyro_bias[i] <= div_quot[i];
        end
      end
      for (int i = 0; i < ACCEL_AXES; i++) begin
        if (accel_clear) begin
          accel_bias[i] <= '0;
        end else if (div_rsp.valid && div_rsp.is_accel) begin
          accel_bias[i] <= div_quot[i];
        end
      end
      if (take_sample) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // accel Z is never summed, so its offset stays zero
  always_ff @(posedge clk) begin
    if (take_sample) begin
      accel_x            <= acc_c[0];
      accel_y            <= acc_c[1];
      accel_z            <= accel_z_raw;
      gyro_x             <= gyr_c[0];
      gyro_y             <= gyr_c[1];
      gyro_z             <= gyr_c[2];
      gyro_offset_saved  <= gsaved;
      accel_offset_saved <= asaved;
      gyro_calibrated    <= gyro_done_next;
      accel_calibrated   <= accel_done_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imucal_chk.sv =====
`default_nettype none

module imucal_chk (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              sample_valid,
  input wire logic              sample_stall,
  input wire imucal_pkg::cmd_t  command,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire imucal_pkg::data_t gyro_x,
  input wire logic              gyro_offset_saved,
  input wire logic              accel_offset_saved,
  input wire logic              gyro_calibrated,
  input wire logic              accel_calibrated
);
  import imucal_pkg::*;

  logic sample_txn;
  assign sample_txn = sample_valid && !sample_stall;

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(gyro_x)))
    else $error("stalled result dropped or changed");

  a_saved_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!(gyro_offset_saved && accel_offset_saved)
      && (!gyro_offset_saved || gyro_calibrated)
      && (!accel_offset_saved || accel_calibrated)))
    else $error("inconsistent calibration flags");

  a_divide_hold: assert property (@(posedge clk) disable iff (rst)
    (sample_txn && command == CMD_SAMPLE)
      |=> (!(gyro_offset_saved || accel_offset_saved) || sample_stall))
    else $error("sample taken while offsets are being computed");

  a_no_result: assert property (@(posedge clk) disable iff (rst)
    (sample_txn && command != CMD_SAMPLE && !(result_valid && result_stall))
      |=> !result_valid)
    else $error("result from a command transaction");

endmodule

bind imu_offset_calibration_unit imucal_chk u_chk (.*);

`default_nettype wire
